// File: sv/trle_pkg.sv
package trle_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  RUN_FLAG    = 8'h80;
    localparam logic [7:0]  COUNT_MASK  = 8'h7F;
    localparam logic [15:0] WORD15_MASK = 16'h7FFF;

    localparam int unsigned CFG_ADDR_W = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BYTES_PER_PIXEL  = 2'd0;
    localparam logic [1:0] REG_RUN_LENGTH_CODED = 2'd1;
    localparam logic [1:0] REG_PIXEL_TOTAL      = 2'd2;

    // Decoding settings shared by the front and the back.
    typedef struct packed {
        logic [2:0] size;
        logic       coded;
    } t_cfg;

    // One word passed from the front to the back.
    typedef struct packed {
        logic        is_header;
        logic        packet_end;
        logic [7:0]  count;
        logic [31:0] assembly;
    } t_entry;

    // Pixel size as decoded: zero acts as one byte, five to seven as four.
    function automatic logic [2:0] size_in_use(input logic [2:0] raw);
        logic [2:0] s;
        s = raw;
        if (raw == 3'd0) s = 3'd1;
        else if (raw > 3'd4) s = 3'd4;
        return s;
    endfunction

endpackage

// File: sv/tga_rle_pixel_decoder_core.sv
// TGA run-length pixel decoder.
// Input channel: one byte of image pixel data per word, written with push
// while full is low. Result channel: one decoded pixel per word, with its
// repeat count and a last flag, read with pop while empty is low.
// Configuration goes through the APB-style port: bytes per pixel at 0x0,
// run-length coding enable at 0x4 and the pixel total at 0x8. Any write,
// also one to an unused address, restarts decoding at a new image.
// The input takes one byte per cycle while full is low. Header bytes and the leading
// bytes of a pixel give no result; the byte that completes a pixel reaches
// the result ports through the front-to-back queue and then the output
// register.
// Reset empties the queue and the output register, loads the register
// defaults (one byte per pixel, raw data, one pixel) and waits for a
// new image. While the receiver holds off pop, the output register keeps
// its pixel, the queue fills behind it, and full rises once it is full.
module tga_rle_pixel_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = trle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trle_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Byte input.
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_data_byte,
    // Pixel output.
    output logic                          empty,
    input  logic                          pop,
    output logic [31:0]                   o_pixel_word,
    output logic [7:0]                    o_repeat_count,
    output logic                          o_last
);
    import trle_pkg::*;

    logic [2:0]  r_bytes_per_pixel;
    logic        r_run_length_coded;
    logic [31:0] r_pixel_total;

    logic        cfg_write;
    logic [1:0]  reg_index;
    t_cfg        cfg;

    logic        byte_accept;
    logic        front_valid;
    t_entry      front_entry;
    logic        queue_full;
    logic        queue_valid;
    t_entry      queue_entry;
    logic        back_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_pixel  <= 3'd1;
            r_run_length_coded <= 1'b0;
            r_pixel_total      <= 32'd1;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_BYTES_PER_PIXEL:  r_bytes_per_pixel  <= pwdata[2:0];
                REG_RUN_LENGTH_CODED: r_run_length_coded <= pwdata[0];
                REG_PIXEL_TOTAL:      r_pixel_total      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_BYTES_PER_PIXEL:  prdata = {29'd0, r_bytes_per_pixel};
            REG_RUN_LENGTH_CODED: prdata = {31'd0, r_run_length_coded};
            REG_PIXEL_TOTAL:      prdata = r_pixel_total;
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.size  = size_in_use(r_bytes_per_pixel);
    assign cfg.coded = r_run_length_coded;

    // The front only advances when the queue can take whatever it produces.
    assign full        = queue_full;
    assign byte_accept = push && !queue_full;

    trle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_write),
        .i_cfg         (cfg),
        .i_valid       (byte_accept),
        .i_data_byte   (i_data_byte),
        .o_entry_valid (front_valid),
        .o_entry       (front_entry)
    );

    trle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (cfg_write),
        .i_write (front_valid),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_entry (queue_entry),
        .i_take  (back_take)
    );

    trle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_write),
        .i_cfg          (cfg),
        .i_pixel_total  (r_pixel_total),
        .i_entry_valid  (queue_valid),
        .i_entry        (queue_entry),
        .o_entry_take   (back_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_word   (o_pixel_word),
        .o_repeat_count (o_repeat_count),
        .o_last         (o_last)
    );

endmodule

// File: sv/trle_front.sv
module trle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_restart,
    input  trle_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    output logic            o_entry_valid,
    output trle_pkg::t_entry o_entry
);
    import trle_pkg::*;

    logic        r_expect_header, n_expect_header;
    logic        r_packet_is_run, n_packet_is_run;
    logic [7:0]  r_packet_left,   n_packet_left;
    logic [1:0]  r_byte_position, n_byte_position;
    logic [31:0] r_assembly,      n_assembly;

    logic [31:0] assembly_next;
    logic        pixel_done;
    logic [7:0]  count;
    logic [7:0]  left_after;

    assign assembly_next = r_assembly | ({24'd0, i_data_byte} << {r_byte_position, 3'b000});
    assign pixel_done    = ({1'b0, r_byte_position} + 3'd1) >= i_cfg.size;
    assign count         = (i_data_byte & COUNT_MASK) + 8'd1;

    always_comb begin
        n_expect_header = r_expect_header;
        n_packet_is_run = r_packet_is_run;
        n_packet_left   = r_packet_left;
        n_byte_position = r_byte_position;
        n_assembly      = r_assembly;
        o_entry_valid   = 1'b0;
        o_entry         = '0;
        left_after      = 8'd0;

        if (i_valid) begin
            if (i_cfg.coded && r_expect_header) begin
                n_packet_is_run  = (i_data_byte & RUN_FLAG) != 8'd0;
                n_packet_left    = count;
                n_expect_header  = 1'b0;
                n_byte_position  = 2'd0;
                n_assembly       = 32'd0;
                o_entry_valid    = 1'b1;
                o_entry.is_header = 1'b1;
                o_entry.count    = count;
            end else if (!pixel_done) begin
                n_byte_position = r_byte_position + 2'd1;
                n_assembly      = assembly_next;
            end else begin
                n_byte_position  = 2'd0;
                n_assembly       = 32'd0;
                o_entry_valid    = 1'b1;
                o_entry.assembly = assembly_next;
                o_entry.count    = 8'd1;
                if (i_cfg.coded) begin
                    if (r_packet_is_run) begin
                        o_entry.count = r_packet_left;
                        left_after    = 8'd0;
                    end else begin
                        left_after = (r_packet_left != 8'd0) ? r_packet_left - 8'd1 : 8'd0;
                    end
                    n_packet_left      = left_after;
                    o_entry.packet_end = (left_after == 8'd0);
                    if (left_after == 8'd0) n_expect_header = 1'b1;
                end
            end
        end

        if (i_restart) begin
            n_expect_header = 1'b1;
            n_packet_is_run = 1'b0;
            n_packet_left   = 8'd0;
            n_byte_position = 2'd0;
            n_assembly      = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_position <= 2'd0;
            r_assembly      <= 32'd0;
        end else begin
            r_expect_header <= n_expect_header;
            r_packet_is_run <= n_packet_is_run;
            r_packet_left   <= n_packet_left;
            r_byte_position <= n_byte_position;
            r_assembly      <= n_assembly;
        end
    end

endmodule

// File: sv/trle_queue.sv
module trle_queue #(
    parameter int unsigned DEPTH = trle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_flush,
    input  logic             i_write,
    input  trle_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    output trle_pkg::t_entry o_entry,
    input  logic             i_take
);
    import trle_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_write, do_take;

    assign o_full   = (r_cnt == FULL_CNT);
    assign o_valid  = (r_cnt != '0);
    assign o_entry  = r_mem[r_rd];
    assign do_write = i_write && !o_full;
    assign do_take  = i_take && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_write) n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        if (do_take)  n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        if (do_write && !do_take) n_cnt = r_cnt + CNT_W'(1);
        else if (!do_write && do_take) n_cnt = r_cnt - CNT_W'(1);
        if (i_flush) begin
            n_wr  = '0;
            n_rd  = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) r_mem[r_wr] <= i_entry;
    end

endmodule

// File: sv/trle_back.sv
module trle_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  trle_pkg::t_cfg   i_cfg,
    input  logic [31:0]      i_pixel_total,
    input  logic             i_entry_valid,
    input  trle_pkg::t_entry i_entry,
    output logic             o_entry_take,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [31:0]      o_pixel_word,
    output logic [7:0]       o_repeat_count,
    output logic             o_last
);
    import trle_pkg::*;

    logic [32:0] r_remaining, n_remaining;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_pixel_word;
    logic [7:0]  r_repeat_count;
    logic        r_last;

    logic [32:0] rem_loaded;
    logic [32:0] count_wide;
    logic [31:0] word;
    logic        last_bit;
    logic [31:0] a;

    assign a          = i_entry.assembly;
    assign rem_loaded = (r_remaining != 33'd0) ? r_remaining
                      : ((i_pixel_total != 32'd0) ? {1'b0, i_pixel_total} : 33'd1);
    assign count_wide = {25'd0, i_entry.count};
    assign o_entry_take = i_entry_valid && (!r_out_valid || i_pop);

    // Reorder blue-green-red into red-green-blue; two-byte pixels are masked to 15 bits only when not run-length coded.
    always_comb begin
        unique case (i_cfg.size)
            3'd1:    word = {24'd0, a[7:0]};
            3'd2:    word = i_cfg.coded ? {16'd0, a[15:0]} : {16'd0, a[15:0] & WORD15_MASK};
            3'd3:    word = {8'd0, a[7:0], a[15:8], a[23:16]};
            default: word = {a[31:24], a[7:0], a[15:8], a[23:16]};
        endcase
    end

    always_comb begin
        n_remaining = r_remaining;
        n_out_valid = r_out_valid && !i_pop;
        last_bit    = 1'b0;
        if (o_entry_take) begin
            if (i_entry.is_header) begin
                n_remaining = (rem_loaded > count_wide) ? rem_loaded - count_wide : 33'd0;
            end else begin
                n_out_valid = 1'b1;
                if (i_cfg.coded) begin
                    last_bit = i_entry.packet_end && (r_remaining == 33'd0);
                end else begin
                    n_remaining = rem_loaded - 33'd1;
                    last_bit    = (n_remaining == 33'd0);
                end
            end
        end
        if (i_restart) begin
            n_remaining = 33'd0;
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_entry_take && !i_entry.is_header) begin
            r_pixel_word   <= word;
            r_repeat_count <= i_entry.count;
            r_last         <= last_bit;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_pixel_word   = r_pixel_word;
    assign o_repeat_count = r_repeat_count;
    assign o_last         = r_last;

endmodule
